@@ design/assert_macros.svh @@
// Assertion macros shared by the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define FQS_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define FQS_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`else

`define FQS_ASSERT(lbl, clk, rstn, prop, msg)

`define FQS_ASSERT_NEVER(lbl, clk, rstn, cond, msg)

`endif

`endif

@@ design/fqs_pkg.sv @@
`timescale 1ns / 1ps

package fqs_pkg;

  localparam int NPROC_DEF  = 16;
  localparam int LEVELS_DEF = 8;
  localparam int QDEPTH     = 2;
  localparam int SVC_W      = 10;
  localparam int TIME_W     = 16;
  localparam int OUT_SLOT_W = 4;
  localparam int OUT_LVL_W  = 3;

  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;

  typedef struct packed {
    logic             mode;
    logic [SVC_W-1:0] svc;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } head_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_SCAN,
    B_LAST,
    B_RUN
  } back_state_t;

endpackage

@@ design/fqs_front.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fqs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic                          in_mode,
  input  logic [fqs_pkg::SVC_W-1:0]     in_service_time,
  output logic                          busy,
  input  logic                          pop,
  output fqs_pkg::head_t                head
);

  localparam int QD    = fqs_pkg::QDEPTH;
  localparam int PTR_W = (QD > 1) ? $clog2(QD) : 1;
  localparam int CNT_W = $clog2(QD + 1);

  fqs_pkg::item_t     q_r [QD];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               push;
  fqs_pkg::item_t     new_item;

  assign busy = (count_r == CNT_W'(QD));
  assign push = start && !busy;

  always_comb begin
    new_item.mode = (in_mode == fqs_pkg::MODE_TICK) ? fqs_pkg::MODE_TICK
                                                    : fqs_pkg::MODE_ARRIVE;
    new_item.svc  = in_service_time;
  end

  assign head.valid = (count_r != '0);
  assign head.item  = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QD - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QD - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_item;
    end
  end

  `FQS_ASSERT_NEVER(a_pop_empty, clk, rst_n, pop && (count_r == '0), "pop from empty queue")
  `FQS_ASSERT_NEVER(a_count_ovf, clk, rst_n, count_r > CNT_W'(QD), "queue count overflow")

endmodule

@@ design/fqs_back.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fqs_back #(
  parameter int NPROC  = fqs_pkg::NPROC_DEF,
  parameter int LEVELS = fqs_pkg::LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_doubling,
  input  fqs_pkg::head_t                    head,
  output logic                              pop,
  output logic                              out_valid,
  output logic [fqs_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic                              out_accepted,
  output logic                              out_done_res,
  output logic [fqs_pkg::TIME_W-1:0]        out_finish_time,
  output logic [fqs_pkg::OUT_LVL_W-1:0]     out_level
);

  localparam int SLOT_W = $clog2(NPROC);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int SL_W   = LEVELS;
  localparam int NF_W   = $clog2(NPROC + 1);
  localparam int SVC_W  = fqs_pkg::SVC_W;
  localparam int TW     = fqs_pkg::TIME_W;
  localparam int OSW    = fqs_pkg::OUT_SLOT_W;
  localparam int OLW    = fqs_pkg::OUT_LVL_W;

  typedef struct packed {
    logic [SVC_W-1:0] rem;
    logic [LVL_W-1:0] lvl;
  } entry_t;

  fqs_pkg::back_state_t state_r, state_nxt;

  entry_t             mem_r [NPROC];
  entry_t             mem_rd_r;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_wa;
  entry_t             mem_wd;

  logic               doubling_r, doubling_nxt;
  logic [NPROC-1:0]   waiting_r, waiting_nxt;
  logic               held_valid_r, held_valid_nxt;
  logic [SLOT_W-1:0]  held_slot_r, held_slot_nxt;
  logic [SVC_W-1:0]   held_rem_r, held_rem_nxt;
  logic [LVL_W-1:0]   held_lvl_r, held_lvl_nxt;
  logic [SL_W-1:0]    slice_r, slice_nxt;
  logic [TW-1:0]      now_r, now_nxt;
  logic [NF_W-1:0]    next_free_r, next_free_nxt;
  logic [SLOT_W-1:0]  scan_idx_r, scan_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [SLOT_W-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic               found_r, found_nxt;
  logic [SLOT_W-1:0]  best_slot_r, best_slot_nxt;
  logic [SVC_W-1:0]   best_rem_r, best_rem_nxt;
  logic [LVL_W-1:0]   best_lvl_r, best_lvl_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [OSW-1:0]     out_slot_r, out_slot_nxt;
  logic               out_acc_r, out_acc_nxt;
  logic               out_done_r, out_done_nxt;
  logic [TW-1:0]      out_fin_r, out_fin_nxt;
  logic [OLW-1:0]     out_lvl_r, out_lvl_nxt;

  logic               do_arrive, do_tick, do_scan, do_run;
  logic [SLOT_W-1:0]  arr_slot;
  logic               dispatch, runs;
  logic [SLOT_W-1:0]  cur_slot;
  logic [SVC_W-1:0]   cur_rem, rem_dec;
  logic [LVL_W-1:0]   cur_lvl, req_lvl;
  logic [SL_W-1:0]    cur_slice, slice_dec;
  logic [TW-1:0]      now_inc;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      fqs_pkg::B_IDLE: begin
        if (head.valid && head.item.mode == fqs_pkg::MODE_TICK) begin
          state_nxt = (held_valid_r && slice_r != '0) ? fqs_pkg::B_RUN : fqs_pkg::B_SCAN;
        end
      end
      fqs_pkg::B_SCAN: begin
        if (scan_idx_r == SLOT_W'(NPROC - 1)) begin
          state_nxt = fqs_pkg::B_LAST;
        end
      end
      fqs_pkg::B_LAST: begin
        state_nxt = fqs_pkg::B_RUN;
      end
      fqs_pkg::B_RUN: begin
        state_nxt = fqs_pkg::B_IDLE;
      end
    endcase
  end

  always_comb begin
    pop       = (state_r == fqs_pkg::B_IDLE) && head.valid;
    do_arrive = pop && (head.item.mode == fqs_pkg::MODE_ARRIVE);
    do_tick   = pop && (head.item.mode == fqs_pkg::MODE_TICK);
    do_scan   = (state_r == fqs_pkg::B_SCAN);
    do_run    = (state_r == fqs_pkg::B_RUN);
  end

  assign arr_slot  = next_free_r[SLOT_W-1:0];
  assign dispatch  = !held_valid_r && found_r;
  assign runs      = held_valid_r || found_r;
  assign cur_slot  = dispatch ? best_slot_r : held_slot_r;
  assign cur_rem   = dispatch ? best_rem_r : held_rem_r;
  assign cur_lvl   = dispatch ? best_lvl_r : held_lvl_r;
  assign cur_slice = dispatch ? (doubling_r ? (SL_W'(1) << best_lvl_r) : SL_W'(1)) : slice_r;
  assign rem_dec   = (cur_rem != '0) ? cur_rem - SVC_W'(1) : cur_rem;
  assign slice_dec = (cur_slice != '0) ? cur_slice - SL_W'(1) : cur_slice;
  assign now_inc   = now_r + TW'(1);
  assign req_lvl   = ((|waiting_r) && held_lvl_r < LVL_W'(LEVELS - 1))
                     ? held_lvl_r + LVL_W'(1) : held_lvl_r;

  always_comb begin
    doubling_nxt   = doubling_r;
    waiting_nxt    = waiting_r;
    held_valid_nxt = held_valid_r;
    held_slot_nxt  = held_slot_r;
    held_rem_nxt   = held_rem_r;
    held_lvl_nxt   = held_lvl_r;
    slice_nxt      = slice_r;
    now_nxt        = now_r;
    next_free_nxt  = next_free_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_vld_nxt    = do_scan;
    cmp_idx_nxt    = scan_idx_r;
    found_nxt      = found_r;
    best_slot_nxt  = best_slot_r;
    best_rem_nxt   = best_rem_r;
    best_lvl_nxt   = best_lvl_r;
    mem_we         = 1'b0;
    mem_wa         = arr_slot;
    mem_wd         = '{rem: head.item.svc, lvl: '0};
    out_valid_nxt  = 1'b0;
    out_slot_nxt   = '0;
    out_acc_nxt    = 1'b0;
    out_done_nxt   = 1'b0;
    out_fin_nxt    = '0;
    out_lvl_nxt    = '0;

    if (cfg_we) begin
      doubling_nxt = cfg_doubling;
    end

    if (do_arrive) begin
      out_valid_nxt = 1'b1;
      if (next_free_r < NF_W'(NPROC)) begin
        mem_we                = 1'b1;
        waiting_nxt[arr_slot] = (head.item.svc != '0);
        next_free_nxt         = next_free_r + NF_W'(1);
        out_slot_nxt          = OSW'(arr_slot);
        out_acc_nxt           = 1'b1;
        out_done_nxt          = (head.item.svc == '0);
        out_fin_nxt           = (head.item.svc == '0) ? now_r : '0;
      end
    end

    if (do_tick) begin
      scan_idx_nxt = '0;
      found_nxt    = 1'b0;
      if (held_valid_r && slice_r == '0) begin
        mem_we                   = 1'b1;
        mem_wa                   = held_slot_r;
        mem_wd                   = '{rem: held_rem_r, lvl: req_lvl};
        waiting_nxt[held_slot_r] = 1'b1;
        held_valid_nxt           = 1'b0;
      end
    end

    if (do_scan) begin
      scan_idx_nxt = scan_idx_r + SLOT_W'(1);
    end

    if (cmp_vld_r && waiting_r[cmp_idx_r] && (!found_r || mem_rd_r.lvl < best_lvl_r)) begin
      found_nxt     = 1'b1;
      best_slot_nxt = cmp_idx_r;
      best_rem_nxt  = mem_rd_r.rem;
      best_lvl_nxt  = mem_rd_r.lvl;
    end

    if (do_run) begin
      now_nxt       = now_inc;
      out_valid_nxt = 1'b1;
      if (runs) begin
        if (dispatch) begin
          waiting_nxt[best_slot_r] = 1'b0;
        end
        held_slot_nxt  = cur_slot;
        held_rem_nxt   = rem_dec;
        held_lvl_nxt   = cur_lvl;
        slice_nxt      = slice_dec;
        held_valid_nxt = (rem_dec != '0);
        out_slot_nxt   = OSW'(cur_slot);
        out_acc_nxt    = 1'b1;
        out_done_nxt   = (rem_dec == '0);
        out_fin_nxt    = (rem_dec == '0) ? now_inc : '0;
        out_lvl_nxt    = OLW'(cur_lvl);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= fqs_pkg::B_IDLE;
      doubling_r   <= 1'b0;
      waiting_r    <= '0;
      held_valid_r <= 1'b0;
      held_slot_r  <= '0;
      slice_r      <= '0;
      now_r        <= '0;
      next_free_r  <= '0;
      cmp_vld_r    <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      doubling_r   <= doubling_nxt;
      waiting_r    <= waiting_nxt;
      held_valid_r <= held_valid_nxt;
      held_slot_r  <= held_slot_nxt;
      slice_r      <= slice_nxt;
      now_r        <= now_nxt;
      next_free_r  <= next_free_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    held_rem_r  <= held_rem_nxt;
    held_lvl_r  <= held_lvl_nxt;
    scan_idx_r  <= scan_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    best_slot_r <= best_slot_nxt;
    best_rem_r  <= best_rem_nxt;
    best_lvl_r  <= best_lvl_nxt;
    out_slot_r  <= out_slot_nxt;
    out_acc_r   <= out_acc_nxt;
    out_done_r  <= out_done_nxt;
    out_fin_r   <= out_fin_nxt;
    out_lvl_r   <= out_lvl_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    mem_rd_r <= mem_r[scan_idx_r];
  end

  assign out_valid       = out_valid_r;
  assign out_slot        = out_slot_r;
  assign out_accepted    = out_acc_r;
  assign out_done_res    = out_done_r;
  assign out_finish_time = out_fin_r;
  assign out_level       = out_lvl_r;

  `FQS_ASSERT(a_held_not_waiting, clk, rst_n, held_valid_r |-> !waiting_r[held_slot_r], "held slot also waiting")
  `FQS_ASSERT(a_scan_unheld, clk, rst_n, (state_r == fqs_pkg::B_SCAN) |-> !held_valid_r, "scan while a process is held")
  `FQS_ASSERT(a_word_source, clk, rst_n, out_valid_r |-> ($past(state_r == fqs_pkg::B_IDLE) || $past(state_r == fqs_pkg::B_RUN)), "result word from wrong state")

endmodule

@@ design/feedback_queue_scheduler.sv @@
// An arrival is queued, popped by the back end in B_IDLE and answered by a registered result
// word; a tick that continues the held slice passes through B_IDLE and B_RUN; a tick that
// must dispatch passes B_IDLE, B_SCAN, B_LAST and B_RUN, scanning at one slot per cycle.
// Throughput: one item per cycle while the back end is in B_IDLE; ticks stall it. A two-word
// queue lets new items be taken while the scheduler works. The receiver cannot stall.
// Reset (rst_n low, synchronous) clears all control state; slot memory is not cleared.
`timescale 1ns / 1ps

module feedback_queue_scheduler #(
  parameter int NPROC  = fqs_pkg::NPROC_DEF,
  parameter int LEVELS = fqs_pkg::LEVELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_mode,
  input  logic [fqs_pkg::SVC_W-1:0]         in_service_time,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_quantum_doubling,
  output logic                              out_valid,
  output logic [fqs_pkg::OUT_SLOT_W-1:0]    out_slot,
  output logic                              out_accepted,
  output logic                              out_done_res,
  output logic [fqs_pkg::TIME_W-1:0]        out_finish_time,
  output logic [fqs_pkg::OUT_LVL_W-1:0]     out_level
);

  fqs_pkg::head_t head;
  logic           pop;
  logic           cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  fqs_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_mode         (in_mode),
    .in_service_time (in_service_time),
    .busy            (busy),
    .pop             (pop),
    .head            (head)
  );

  fqs_back #(
    .NPROC  (NPROC),
    .LEVELS (LEVELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_doubling    (cfg_quantum_doubling),
    .head            (head),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_slot        (out_slot),
    .out_accepted    (out_accepted),
    .out_done_res    (out_done_res),
    .out_finish_time (out_finish_time),
    .out_level       (out_level)
  );

endmodule
